// ===== rtl/causal_attention_mask_stream_top_defines.svh =====
// Assertion macros used by the checker file.
`ifndef CAUSAL_ATTENTION_MASK_STREAM_TOP_DEFINES_SVH
`define CAUSAL_ATTENTION_MASK_STREAM_TOP_DEFINES_SVH

// Clocked assertion, off while reset is held.
`define CAM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define CAM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/cam_pkg.sv =====
package cam_pkg;

  localparam int CFG_W = 13;
  localparam int IDX_W = 3;
  localparam int DATA_W = 32;

  localparam logic [IDX_W-1:0] CFG_ROW_COUNT   = 3'd0;
  localparam logic [IDX_W-1:0] CFG_ROW_LEN     = 3'd1;
  localparam logic [IDX_W-1:0] CFG_WINDOW_MODE = 3'd2;
  localparam logic [IDX_W-1:0] CFG_WINDOW_LEN  = 3'd3;
  localparam logic [IDX_W-1:0] CFG_ELEM_FORMAT = 3'd4;

  localparam logic [DATA_W-1:0] MASK_FP16 = 32'h0000_FBFF;
  localparam logic [DATA_W-1:0] MASK_FP32 = 32'hD015_02F9;

  typedef struct packed {
    logic [CFG_W-1:0] row_count;
    logic [CFG_W-1:0] row_len;
    logic             window_mode;
    logic [CFG_W-1:0] window_len;
    logic             elem_format;
  } cfg_t;

  typedef struct packed {
    logic masked;
    logic bad;
  } mask_info_t;

endpackage

// ===== rtl/cam_mask.sv =====
module cam_mask #(
  parameter int MAX_DIM = 4096,
  parameter int CNT_W   = 12
) (
  input  cam_pkg::cfg_t       cfg,
  input  logic [CNT_W-1:0]    row_i,
  input  logic [CNT_W-1:0]    col_i,
  output cam_pkg::mask_info_t info,
  output logic [CNT_W-1:0]    row_nxt,
  output logic [CNT_W-1:0]    col_nxt
);

  localparam int CMP_W = ((CNT_W > cam_pkg::CFG_W) ? CNT_W : cam_pkg::CFG_W) + 2;

  logic [CMP_W-1:0] row_e;
  logic [CMP_W-1:0] col_e;
  logic [CMP_W-1:0] rcnt_e;
  logic [CMP_W-1:0] rlen_e;
  logic [CMP_W-1:0] wlen_e;
  logic [CMP_W-1:0] diag;
  logic             bad;
  logic             std_mask;
  logic             win_mask;
  logic             col_wrap;
  logic             row_wrap;

  assign row_e  = CMP_W'(row_i);
  assign col_e  = CMP_W'(col_i);
  assign rcnt_e = CMP_W'(cfg.row_count);
  assign rlen_e = CMP_W'(cfg.row_len);
  assign wlen_e = CMP_W'(cfg.window_len);

  assign bad = (cfg.row_count == '0) || (32'(cfg.row_count) > 32'(MAX_DIM)) ||
               (cfg.row_len == '0) || (32'(cfg.row_len) > 32'(MAX_DIM)) ||
               (cfg.row_len < cfg.row_count) ||
               (cfg.window_mode && (cfg.window_len == '0));

  assign diag     = rlen_e - rcnt_e + row_e + CMP_W'(1);
  assign std_mask = (col_e >= diag);
  assign win_mask = ((col_e + wlen_e) < (row_e + CMP_W'(1))) || (col_e > row_e);

  assign info.bad    = bad;
  assign info.masked = !bad && (cfg.row_count != cam_pkg::CFG_W'(1)) &&
                       (cfg.window_mode ? win_mask : std_mask);

  assign col_wrap = ((col_e + CMP_W'(1)) >= rlen_e);
  assign row_wrap = ((row_e + CMP_W'(1)) >= rcnt_e);

  always_comb begin
    if (bad) begin
      row_nxt = '0;
      col_nxt = '0;
    end else if (col_wrap) begin
      col_nxt = '0;
      row_nxt = row_wrap ? '0 : CNT_W'(row_e + CMP_W'(1));
    end else begin
      col_nxt = CNT_W'(col_e + CMP_W'(1));
      row_nxt = row_i;
    end
  end

endmodule

// ===== rtl/causal_attention_mask_stream_top.sv =====
// Causal / sliding-window attention mask over a row-major stream of score
// elements. One element is accepted every cycle while the input is not stalled;
// it is held in an input register and its result is then offered from a
// result register. The row and column counters are compared and advanced
// between the two registers. A stalled output holds its result; with both
// registers full the input stalls until that result transfers.
// Masked elements are replaced by 0x0000FBFF (fp16) or 0xD01502F9 (fp32);
// others pass with all 32 bits intact. An invalid configuration passes data
// and sets bad_config. Any write to a defined register restarts the counters
// at the top of a matrix; write registers only while no element is in flight.
module causal_attention_mask_stream_top #(
  parameter int MAX_DIM = 4096
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [cam_pkg::DATA_W-1:0]        in_tdata,   // [31:0] score_bits
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [cam_pkg::DATA_W-1:0]        out_tdata,  // [31:0] score_out
  output logic [7:0]                        out_tuser,  // [0] was_masked, [1] bad_config
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [cam_pkg::IDX_W-1:0]         cfg_index,
  input  logic [cam_pkg::CFG_W-1:0]         cfg_data
);

  localparam int CNT_W = (MAX_DIM > 2) ? $clog2(MAX_DIM) : 1;

  cam_pkg::cfg_t       cfg_r;
  cam_pkg::mask_info_t info;
  logic [CNT_W-1:0]    row_r;
  logic [CNT_W-1:0]    col_r;
  logic [CNT_W-1:0]    row_nxt;
  logic [CNT_W-1:0]    col_nxt;
  logic                s1_v_r;
  logic [cam_pkg::DATA_W-1:0] s1_data_r;
  logic                s2_v_r;
  logic [cam_pkg::DATA_W-1:0] s2_data_r;
  logic                s2_masked_r;
  logic                s2_bad_r;
  logic                in_fire;
  logic                s2_load;
  logic                cfg_fire;
  logic                cfg_hit;

  assign cfg_ready = rst_n;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign s2_load   = s1_v_r && (!s2_v_r || out_tready);
  assign in_tready = rst_n && (!s1_v_r || s2_load);
  assign in_fire   = in_tvalid && in_tready;

  cam_mask #(
    .MAX_DIM (MAX_DIM),
    .CNT_W   (CNT_W)
  ) u_mask (
    .cfg     (cfg_r),
    .row_i   (row_r),
    .col_i   (col_r),
    .info    (info),
    .row_nxt (row_nxt),
    .col_nxt (col_nxt)
  );

  always_comb begin
    unique case (cfg_index)
      cam_pkg::CFG_ROW_COUNT,
      cam_pkg::CFG_ROW_LEN,
      cam_pkg::CFG_WINDOW_MODE,
      cam_pkg::CFG_WINDOW_LEN,
      cam_pkg::CFG_ELEM_FORMAT: cfg_hit = 1'b1;
      default:                  cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.row_count   <= cam_pkg::CFG_W'(1);
      cfg_r.row_len     <= cam_pkg::CFG_W'(1);
      cfg_r.window_mode <= 1'b0;
      cfg_r.window_len  <= cam_pkg::CFG_W'(1);
      cfg_r.elem_format <= 1'b0;
    end else if (cfg_fire) begin
      unique case (cfg_index)
        cam_pkg::CFG_ROW_COUNT:   cfg_r.row_count   <= cfg_data;
        cam_pkg::CFG_ROW_LEN:     cfg_r.row_len     <= cfg_data;
        cam_pkg::CFG_WINDOW_MODE: cfg_r.window_mode <= cfg_data[0];
        cam_pkg::CFG_WINDOW_LEN:  cfg_r.window_len  <= cfg_data;
        cam_pkg::CFG_ELEM_FORMAT: cfg_r.elem_format <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // restart at the matrix origin on a write to a defined register, advance per element loaded into the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else if (cfg_fire && cfg_hit) begin
      row_r <= '0;
      col_r <= '0;
    end else if (s2_load) begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_v_r <= 1'b1;
      end else if (s2_load) begin
        s1_v_r <= 1'b0;
      end
      if (s2_load) begin
        s2_v_r <= 1'b1;
      end else if (out_tready) begin
        s2_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_data_r <= in_tdata;
    end
    if (s2_load) begin
      s2_masked_r <= info.masked;
      s2_bad_r    <= info.bad;
      if (info.masked) begin
        s2_data_r <= cfg_r.elem_format ? cam_pkg::MASK_FP32 : cam_pkg::MASK_FP16;
      end else begin
        s2_data_r <= s1_data_r;
      end
    end
  end

  assign out_tvalid = s2_v_r;
  assign out_tdata  = s2_data_r;
  assign out_tuser  = {6'b0, s2_bad_r, s2_masked_r};

endmodule

// ===== rtl/cam_checker.sv =====
`include "causal_attention_mask_stream_top_defines.svh"

module cam_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_tvalid,
  input logic                       out_tready,
  input logic [cam_pkg::DATA_W-1:0] out_tdata,
  input logic [7:0]                 out_tuser
);

  `CAM_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")
  `CAM_ASSERT(a_flags_excl, out_tvalid |-> !(out_tuser[0] && out_tuser[1]), "masked element reported with bad configuration")
  `CAM_ASSERT(a_mask_value, out_tvalid && out_tuser[0] |-> (out_tdata == cam_pkg::MASK_FP16) || (out_tdata == cam_pkg::MASK_FP32), "masked element is not a mask pattern")
  `CAM_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_tvalid, "result valid right after reset")

endmodule

bind causal_attention_mask_stream_top cam_checker u_cam_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ===== tb/causal_attention_mask_stream_top_test.sv =====
`timescale 1ns / 1ps

module causal_attention_mask_stream_top_test;

  localparam int MAX_DIM = 4096;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RANDOM_SCORES = 1000;
  localparam int LONG_HOLD_AT = 200;
  localparam logic [cam_pkg::IDX_W-1:0] CFG_UNUSED = 3'd5;

  typedef logic [cam_pkg::CFG_W-1:0] reg_val_t;

  typedef struct packed {
    logic [cam_pkg::DATA_W-1:0] score;
    logic                       masked;
    logic                       bad;
  } score_res_t;

  typedef enum logic {STEP_SCORE, STEP_WRITE} step_kind_t;

  typedef struct packed {
    step_kind_t                 kind;
    logic [cam_pkg::IDX_W-1:0]  idx;
    logic [cam_pkg::DATA_W-1:0] val;
    logic                       typed;
    score_res_t                 res;
  } step_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_tvalid = 1'b0;
  logic                       in_tready;
  logic [cam_pkg::DATA_W-1:0] in_tdata = '0;
  logic                       out_tvalid;
  logic                       out_tready = 1'b0;
  logic [cam_pkg::DATA_W-1:0] out_tdata;
  logic [7:0]                 out_tuser;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [cam_pkg::IDX_W-1:0]  cfg_index = '0;
  logic [cam_pkg::CFG_W-1:0]  cfg_data = '0;

  causal_attention_mask_stream_top #(
    .MAX_DIM(MAX_DIM)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // mask settings and position counters as the block should hold them
  logic [cam_pkg::CFG_W-1:0] set_rows = 13'd1;
  logic [cam_pkg::CFG_W-1:0] set_cols = 13'd1;
  logic                      set_sliding = 1'b0;
  logic [cam_pkg::CFG_W-1:0] set_wlen = 13'd1;
  logic                      set_fp32 = 1'b0;
  int unsigned               row_pos = 0;
  int unsigned               col_pos = 0;

  score_res_t pending_scores [$];
  score_res_t want;
  int         errors = 0;
  int         burst_left = 0;
  int         cycles = 0;
  int         sent_total = 0;

  logic [cam_pkg::IDX_W-1:0] cfg_regs [5] = '{cam_pkg::CFG_ROW_COUNT, cam_pkg::CFG_ROW_LEN,
                                              cam_pkg::CFG_WINDOW_MODE, cam_pkg::CFG_WINDOW_LEN,
                                              cam_pkg::CFG_ELEM_FORMAT};

  step_t script [0:39] = '{
    '{STEP_SCORE, '0, 32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b0, 1'b0}},
    '{STEP_SCORE, '0, 32'hFFFF_FFFF, 1'b1, '{32'hFFFF_FFFF, 1'b0, 1'b0}},
    '{STEP_WRITE, cam_pkg::CFG_ROW_COUNT, 32'd2, 1'b0, '0},
    '{STEP_WRITE, cam_pkg::CFG_ROW_LEN, 32'd2, 1'b0, '0},
    '{STEP_SCORE, '0, 32'hAAAA_5555, 1'b1, '{32'hAAAA_5555, 1'b0, 1'b0}},
    '{STEP_SCORE, '0, 32'h5555_AAAA, 1'b1, '{cam_pkg::MASK_FP16, 1'b1, 1'b0}},
    '{STEP_SCORE, '0, 32'h1234_5678, 1'b0, '0},
    '{STEP_SCORE, '0, 32'hFFFF_FFFF, 1'b0, '0},
    '{STEP_WRITE, cam_pkg::CFG_ELEM_FORMAT, 32'd1, 1'b0, '0},
    '{STEP_SCORE, '0, 32'hFFFF_0000, 1'b1, '{32'hFFFF_0000, 1'b0, 1'b0}},
    '{STEP_SCORE, '0, 32'h0000_FFFF, 1'b1, '{cam_pkg::MASK_FP32, 1'b1, 1'b0}},
    '{STEP_WRITE, cam_pkg::CFG_WINDOW_MODE, 32'd1, 1'b0, '0},
    '{STEP_WRITE, cam_pkg::CFG_WINDOW_LEN, 32'd0, 1'b0, '0},
    '{STEP_SCORE, '0, 32'h0000_FBFF, 1'b1, '{32'h0000_FBFF, 1'b0, 1'b1}},
    '{STEP_SCORE, '0, 32'hD015_02F9, 1'b1, '{32'hD015_02F9, 1'b0, 1'b1}},
    '{STEP_WRITE, cam_pkg::CFG_WINDOW_LEN, 32'd1, 1'b0, '0},
    '{STEP_SCORE, '0, 32'h8000_0001, 1'b0, '0},
    '{STEP_SCORE, '0, 32'h7FFF_FFFE, 1'b0, '0},
    '{STEP_SCORE, '0, 32'h0F0F_F0F0, 1'b0, '0},
    '{STEP_SCORE, '0, 32'hF0F0_0F0F, 1'b0, '0},
    '{STEP_WRITE, cam_pkg::CFG_WINDOW_LEN, 32'd8191, 1'b0, '0},
    '{STEP_SCORE, '0, 32'hC3C3_3C3C, 1'b0, '0},
    '{STEP_SCORE, '0, 32'h3C3C_C3C3, 1'b0, '0},
    '{STEP_WRITE, cam_pkg::CFG_ROW_COUNT, 32'd0, 1'b0, '0},
    '{STEP_SCORE, '0, 32'hDEAD_BEEF, 1'b1, '{32'hDEAD_BEEF, 1'b0, 1'b1}},
    '{STEP_WRITE, cam_pkg::CFG_ROW_COUNT, 32'd8191, 1'b0, '0},
    '{STEP_SCORE, '0, 32'h0BAD_F00D, 1'b1, '{32'h0BAD_F00D, 1'b0, 1'b1}},
    '{STEP_WRITE, cam_pkg::CFG_ROW_COUNT, 32'd4096, 1'b0, '0},
    '{STEP_SCORE, '0, 32'hFFFF_FFFF, 1'b1, '{32'hFFFF_FFFF, 1'b0, 1'b1}},
    '{STEP_WRITE, cam_pkg::CFG_ROW_LEN, 32'd4097, 1'b0, '0},
    '{STEP_SCORE, '0, 32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b0, 1'b1}},
    '{STEP_WRITE, cam_pkg::CFG_ROW_LEN, 32'd4096, 1'b0, '0},
    '{STEP_WRITE, cam_pkg::CFG_WINDOW_MODE, 32'd0, 1'b0, '0},
    '{STEP_WRITE, cam_pkg::CFG_ELEM_FORMAT, 32'd0, 1'b0, '0},
    '{STEP_SCORE, '0, 32'h1111_1111, 1'b0, '0},
    '{STEP_SCORE, '0, 32'h2222_2222, 1'b0, '0},
    '{STEP_WRITE, CFG_UNUSED, 32'd8191, 1'b0, '0},
    '{STEP_SCORE, '0, 32'h3333_3333, 1'b0, '0},
    '{STEP_WRITE, cam_pkg::CFG_ROW_COUNT, 32'd1, 1'b0, '0},
    '{STEP_SCORE, '0, 32'h4444_4444, 1'b1, '{32'h4444_4444, 1'b0, 1'b0}}
  };

  function automatic score_res_t mask_score(input logic [cam_pkg::DATA_W-1:0] v);
    score_res_t  r;
    int unsigned rows;
    int unsigned cols;
    int unsigned wlen;
    logic        hit;
    rows = 32'(set_rows);
    cols = 32'(set_cols);
    wlen = 32'(set_wlen);
    r.score = v;
    r.masked = 1'b0;
    r.bad = 1'b0;
    if (rows == 0 || rows > MAX_DIM || cols == 0 || cols > MAX_DIM || cols < rows ||
        (set_sliding && wlen == 0)) begin
      r.bad = 1'b1;
      row_pos = 0;
      col_pos = 0;
      return r;
    end
    if (rows == 1) hit = 1'b0;
    else if (!set_sliding) hit = col_pos >= cols - rows + row_pos + 1;
    else hit = (col_pos + wlen < row_pos + 1) || (col_pos > row_pos);
    if (hit) begin
      r.masked = 1'b1;
      r.score = set_fp32 ? cam_pkg::MASK_FP32 : cam_pkg::MASK_FP16;
    end
    if (col_pos + 1 >= cols) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= rows) ? 0 : row_pos + 1;
    end else begin
      col_pos++;
    end
    return r;
  endfunction

  function automatic void apply_reg(input logic [cam_pkg::IDX_W-1:0] idx,
                                    input logic [cam_pkg::CFG_W-1:0] val);
    case (idx)
      cam_pkg::CFG_ROW_COUNT: set_rows = val;
      cam_pkg::CFG_ROW_LEN: set_cols = val;
      cam_pkg::CFG_WINDOW_MODE: set_sliding = val[0];
      cam_pkg::CFG_WINDOW_LEN: set_wlen = val;
      cam_pkg::CFG_ELEM_FORMAT: set_fp32 = val[0];
      default: return;
    endcase
    row_pos = 0;
    col_pos = 0;
  endfunction

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_score(input logic [cam_pkg::DATA_W-1:0] v, input logic typed,
                            input score_res_t fixed);
    int         gap;
    score_res_t r;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata <= v;
    do @(posedge clk); while (!in_tready);
    r = mask_score(v);
    pending_scores.push_back(typed ? fixed : r);
    sent_total++;
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [cam_pkg::IDX_W-1:0] idx,
                           input logic [cam_pkg::CFG_W-1:0] val);
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_scores.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_all(input logic [cam_pkg::CFG_W-1:0] vals [5]);
    int first;
    first = $urandom_range(0, 4);
    if ($urandom_range(0, 7) == 0) write_reg(CFG_UNUSED, reg_val_t'($urandom));
    for (int k = 0; k < 5; k++) write_reg(cfg_regs[(first + k) % 5], vals[(first + k) % 5]);
  endtask

  function automatic logic [cam_pkg::DATA_W-1:0] random_score();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return $urandom_range(0, 1) ? cam_pkg::MASK_FP32 : cam_pkg::MASK_FP16;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [cam_pkg::CFG_W-1:0] vals [5];
    int                        rand_scores;
    int                        n;
    rand_scores = 0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (script[i]) begin
      if (script[i].kind == STEP_WRITE) write_reg(script[i].idx, script[i].val[cam_pkg::CFG_W-1:0]);
      else send_score(script[i].val, script[i].typed, script[i].res);
    end

    // full-size matrix, head of its first row
    vals = '{13'd4096, 13'd4096, 13'd0, 13'd4096, 13'd1};
    write_all(vals);
    repeat (500) send_score(random_score(), 1'b0, '0);

    while (rand_scores < RANDOM_SCORES) begin
      case ($urandom_range(0, 19)) inside
        [0:14]: begin
          vals[0] = reg_val_t'($urandom_range(1, 6));
          vals[1] = reg_val_t'($urandom_range(32'(vals[0]), 32'(vals[0]) + 6));
          vals[3] = reg_val_t'($urandom_range(0, 32'(vals[1]) + 1));
        end
        [15:16]: begin
          vals[0] = $urandom_range(0, 1) ? 13'd1 : reg_val_t'($urandom_range(4095, 4096));
          vals[1] = 13'd4096;
          case ($urandom_range(0, 3))
            0: vals[3] = 13'd1;
            1: vals[3] = 13'd4095;
            2: vals[3] = 13'd4096;
            default: vals[3] = 13'd8191;
          endcase
        end
        [17:18]: begin
          vals[0] = reg_val_t'($urandom);
          vals[1] = reg_val_t'($urandom);
          vals[3] = reg_val_t'($urandom);
        end
        default: begin
          vals[0] = reg_val_t'($urandom_range(2, 8));
          vals[1] = reg_val_t'($urandom_range(1, 32'(vals[0]) - 1));
          vals[3] = reg_val_t'($urandom_range(0, 8));
        end
      endcase
      vals[2] = reg_val_t'($urandom_range(0, 1));
      vals[4] = reg_val_t'($urandom_range(0, 1));
      write_all(vals);
      n = $urandom_range(10, 80);
      repeat (n) send_score(random_score(), 1'b0, '0);
      rand_scores += n;
    end

    in_tvalid <= 1'b0;
    while (pending_scores.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // receiver: stall patterns in stretches, one long hold mid-stream, periodic holds
  initial begin
    int rx_cycles;
    int hold;
    int mode;
    int mode_left;
    bit long_hold_done;
    rx_cycles = 0;
    hold = 0;
    mode = 0;
    mode_left = 0;
    long_hold_done = 1'b0;
    forever begin
      @(negedge clk);
      rx_cycles++;
      if (!long_hold_done && sent_total >= LONG_HOLD_AT) begin
        long_hold_done = 1'b1;
        hold = $urandom_range(150, 300);
      end else if (rx_cycles % 3000 == 1500) begin
        hold = $urandom_range(150, 300);
      end
      if (hold > 0) begin
        hold--;
        out_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 2);
          mode_left = $urandom_range(8, 80);
        end
        mode_left--;
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= 1'($urandom_range(0, 1));
          default: out_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_scores.size() == 0) begin
        errors++;
        $display("%0t: unexpected result score %h tuser %h", $time, out_tdata, out_tuser);
      end else begin
        want = pending_scores.pop_front();
        if (out_tdata !== want.score) begin
          errors++;
          $display("%0t: score_out expected %h actual %h", $time, want.score, out_tdata);
        end
        if (out_tuser[0] !== want.masked) begin
          errors++;
          $display("%0t: was_masked expected %b actual %b", $time, want.masked, out_tuser[0]);
        end
        if (out_tuser[1] !== want.bad) begin
          errors++;
          $display("%0t: bad_config expected %b actual %b", $time, want.bad, out_tuser[1]);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

endmodule
